// ----- src/upd_pkg.sv -----
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam int UPD_QDEPTH = 4;

  // one classified word: one or two decoded bytes
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;
    logic       last;
  } upd_cmd_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] map_plain(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

// ----- src/upd_stream_if.sv -----
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- src/upd_front.sv -----
module upd_front (
  input  logic              clk,
  input  logic              rst_n,
  upd_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push,
  output upd_pkg::upd_cmd_t cmd
);
  import upd_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       accept;
  logic       emit;
  logic [7:0] c;
  logic       last;
  logic [4:0] hi;
  logic [4:0] lo;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;
  assign last        = in_ch.in_last;
  assign hi          = hex_decode(held_r);
  assign lo          = hex_decode(c);
  assign push        = accept && emit;

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    cmd.b0    = map_plain(c);
    cmd.b1    = map_plain(c);
    cmd.two   = 1'b0;
    cmd.last  = last;
    unique case (phase_r)
      PH_PCT: begin
        if (last) begin
          // short escape at string end: literal percent
          emit      = 1'b1;
          cmd.b0    = CH_PERCENT;
          cmd.two   = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          held_nxt  = c;
          phase_nxt = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        if (hi[4] && lo[4]) begin
          emit      = 1'b1;
          cmd.b0    = {hi[3:0], lo[3:0]};
          phase_nxt = PH_IDLE;
        end else if (held_r == CH_PERCENT) begin
          // held byte restarts an escape
          if (last) begin
            emit      = 1'b1;
            cmd.b0    = CH_PERCENT;
            cmd.two   = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            held_nxt  = c;
            phase_nxt = PH_DIGIT;
          end
        end else begin
          emit   = 1'b1;
          cmd.b0 = map_plain(held_r);
          if (c == CH_PERCENT && !last) begin
            phase_nxt = PH_PCT;
          end else begin
            cmd.two   = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        if (c == CH_PERCENT && !last) begin
          phase_nxt = PH_PCT;
        end else begin
          emit      = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule

// ----- src/upd_queue.sv -----
module upd_queue #(
  parameter int DEPTH = upd_pkg::UPD_QDEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  upd_pkg::upd_cmd_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              rvalid,
  output upd_pkg::upd_cmd_t rdata
);
  import upd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  upd_cmd_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

// ----- src/upd_back.sv -----
module upd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  upd_pkg::upd_cmd_t q_data,
  output logic              pop,
  upd_out_if.source         out_ch
);
  import upd_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       sec_valid_r, sec_valid_nxt;
  logic [7:0] sec_byte_r, sec_byte_nxt;
  logic       sec_last_r, sec_last_nxt;
  logic       load;

  assign load            = !out_valid_r || out_ch.ready;
  assign pop             = load && !sec_valid_r && q_valid;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    sec_valid_nxt = sec_valid_r;
    sec_byte_nxt  = sec_byte_r;
    sec_last_nxt  = sec_last_r;
    if (load) begin
      if (sec_valid_r) begin
        // second byte of the previous word
        out_valid_nxt = 1'b1;
        out_byte_nxt  = sec_byte_r;
        out_last_nxt  = sec_last_r;
        sec_valid_nxt = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = q_data.b0;
        out_last_nxt  = q_data.last && !q_data.two;
        sec_valid_nxt = q_data.two;
        sec_byte_nxt  = q_data.b1;
        sec_last_nxt  = q_data.last;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    sec_byte_r <= sec_byte_nxt;
    sec_last_r <= sec_last_nxt;
  end

  a_sec_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> out_valid_r)
    else $error("second byte pending without a first byte on the output");

  a_sec_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> !out_last_r)
    else $error("end flag shown ahead of the pending second byte");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid && !sec_valid_r)
    else $error("queue popped while empty or while a second byte waits");

  a_two_then_sec: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_data.two |=> sec_valid_r)
    else $error("two-byte word lost its second byte");

endmodule

// ----- src/url_percent_decode.sv -----
// path: front stage -> command queue -> back stage output register -> out_ch
// throughput: one input word per cycle while the queue is not full; a word giving
//   two bytes holds the output for its second byte, absorbed by the command queue
// in_ch.ready drops only when the command queue is full
// reset: synchronous, active low; clears the pending escape, the queue and out_ch.valid
module url_percent_decode #(
  parameter int QDEPTH = upd_pkg::UPD_QDEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  upd_in_if.sink    in_ch,
  upd_out_if.source out_ch
);
  import upd_pkg::*;

  upd_cmd_t push_cmd;
  upd_cmd_t q_data;
  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     pop;

  upd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  upd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (push_cmd),
    .full   (q_full),
    .pop    (pop),
    .rvalid (q_valid),
    .rdata  (q_data)
  );

  upd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import upd_pkg::*;

  localparam int HEX_RADIX   = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_WORDS = 630;
  localparam int STALL_LEN   = 300;
  localparam int DRAIN_WAIT  = 20;

  // predicts the decoded bytes of each accepted word and holds them in order
  class decode_board;
    typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_DIGIT} esc_t;

    esc_t       esc;
    logic [7:0] held;
    logic [7:0] step[$];
    logic [8:0] expected[$];  // {last, byte}
    int         words;
    int         results;
    int         strings;

    function new();
      esc = ESC_NONE;
      held = '0;
      words = 0;
      results = 0;
      strings = 0;
    endfunction

    local function int nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
    endfunction

    local function logic [7:0] plain(logic [7:0] c);
      return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    local function void take_plain(logic [7:0] c, logic last);
      if (c == CH_PERCENT && !last) begin
        esc = ESC_PCT;
      end else begin
        esc = ESC_NONE;
        step.insert(step.size(), plain(c));
      end
    endfunction

    // a '%' is pending and c is the byte right after it
    local function void take_after_pct(logic [7:0] c, logic last);
      if (last) begin
        esc = ESC_NONE;
        step.insert(step.size(), CH_PERCENT);
        step.insert(step.size(), plain(c));
      end else begin
        held = c;
        esc = ESC_DIGIT;
      end
    endfunction

    function void note_input(logic [7:0] c, logic last);
      int         hi;
      int         lo;
      logic [7:0] val;
      logic [8:0] item;
      step.delete();
      words++;
      case (esc)
        ESC_PCT: begin
          take_after_pct(c, last);
        end
        ESC_DIGIT: begin
          hi = nibble(held);
          lo = nibble(c);
          if (hi >= 0 && lo >= 0) begin
            esc = ESC_NONE;
            val = 8'(hi * HEX_RADIX + lo);
            step.insert(step.size(), val);
          end else if (held == CH_PERCENT) begin
            // the held '%' becomes the new escape start
            take_after_pct(c, last);
          end else begin
            step.insert(step.size(), plain(held));
            take_plain(c, last);
          end
        end
        default: begin
          take_plain(c, last);
        end
      endcase
      foreach (step[i]) begin
        item = {last && (i == step.size() - 1), step[i]};
        expected.insert(expected.size(), item);
      end
      if (last) strings++;
    endfunction

    function bit check_output(logic [7:0] b, logic l, output string why);
      logic [8:0] want;
      if (expected.size() == 0) begin
        why = $sformatf("unexpected word: byte %02h last %0b", b, l);
        return 0;
      end
      want = expected.pop_front();
      results++;
      if (want[7:0] !== b || want[8] !== l) begin
        why = $sformatf("word %0d: byte %02h last %0b, expected byte %02h last %0b",
                        results, b, l, want[7:0], want[8]);
        return 0;
      end
      why = "";
      return 1;
    endfunction

    function int waiting();
      return expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  upd_in_if  in_ch ();
  upd_out_if out_ch ();

  url_percent_decode dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decode_board board = new();

  int errors     = 0;
  int send_idle  = 0;
  int recv_idle  = 0;
  int stall_left = 0;
  int sent_words = 0;
  int cycle_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string why);
    errors++;
    $display("mismatch: %s", why);
  endtask

  // input side monitor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      board.note_input(in_ch.in_byte, in_ch.in_last);
    end
  end

  // output side monitor
  always @(posedge clk) begin
    string why;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (!board.check_output(out_ch.out_byte, out_ch.out_last, why)) begin
        report_mismatch(why);
      end
    end
  end

  // receiver, with its own count for a long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("testbench failed");
    $finish;
  end

  task automatic send_word(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    sent_words++;
  endtask

  task automatic send_bytes(logic [7:0] s[$]);
    foreach (s[i]) send_word(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(string t);
    logic [7:0] s[$];
    for (int i = 0; i < t.len(); i++) s.insert(s.size(), t[i]);
    send_bytes(s);
  endtask

  function automatic logic [7:0] rand_hex();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(21)];
  endfunction

  function automatic logic [7:0] rand_non_hex();
    if ($urandom_range(1)) return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range("g", "z"));
  endfunction

  // mostly well-formed strings with random content, some pure noise
  task automatic send_random_string();
    logic [7:0] s[$];
    int         tokens;
    int         kind;
    tokens = $urandom_range(1, 8);
    if ($urandom_range(9) == 0) begin
      repeat (tokens) s.insert(s.size(), 8'($urandom_range(255)));
    end else begin
      repeat (tokens) begin
        kind = $urandom_range(99);
        if (kind < 40) begin
          s.insert(s.size(), CH_PERCENT);
          s.insert(s.size(), rand_hex());
          s.insert(s.size(), rand_hex());
        end else if (kind < 50) begin
          s.insert(s.size(), CH_PLUS);
        end else if (kind < 62) begin
          s.insert(s.size(), 8'($urandom_range(255)));
        end else if (kind < 72) begin
          s.insert(s.size(), CH_PERCENT);
        end else if (kind < 84) begin
          // broken escape: at least one of the pair is not hex
          s.insert(s.size(), CH_PERCENT);
          if ($urandom_range(1)) begin
            s.insert(s.size(), rand_non_hex());
            s.insert(s.size(), 8'($urandom_range(255)));
          end else begin
            s.insert(s.size(), rand_hex());
            s.insert(s.size(), rand_non_hex());
          end
        end else begin
          s.insert(s.size(), 8'($urandom_range("a", "z")));
        end
      end
      // dangling escape at the end of the string
      kind = $urandom_range(9);
      if (kind < 2) begin
        s.insert(s.size(), CH_PERCENT);
      end else if (kind < 4) begin
        s.insert(s.size(), CH_PERCENT);
        s.insert(s.size(), rand_hex());
      end
    end
    send_bytes(s);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (board.waiting() != 0);
  endtask

  task automatic run_phase(int words);
    int stop_at;
    stop_at = sent_words + words;
    while (sent_words < stop_at) send_random_string();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.in_last <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 31;
    recv_idle = 57;
    send_text("%41");
    send_text("%fF");
    send_text("+");
    send_text("%");
    send_text("a%");
    send_text("%+");
    send_text("%g1x");
    send_text("%%41");
    send_bytes('{8'h80, 8'hFF, CH_PERCENT, 8'h8A, 8'h31});
    send_bytes('{8'h00});
    run_phase(PHASE_WORDS);

    // sender holds until every decoded byte is out
    in_ch.valid <= 1'b0;
    wait_drained();
    send_idle = 57;
    recv_idle = 31;
    run_phase(PHASE_WORDS);

    send_idle = 0;
    recv_idle = 0;
    // long receiver hold-off while the sender keeps pushing
    stall_left = STALL_LEN;
    run_phase(PHASE_WORDS);

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d input words in %0d strings, %0d decoded bytes checked",
             board.words, board.strings, board.results);
    $display("escapes, plus signs, broken and dangling escapes, high bytes, stalls");
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/upd_pkg.sv
src/upd_stream_if.sv
src/upd_front.sv
src/upd_queue.sv
src/upd_back.sv
src/url_percent_decode.sv
test/testbench.sv
